### rtl/core/vsm_pkg.sv
// ----------------------------------------------------------------------------
// vsm_pkg
// Types and fixed constants shared by the vector stability monitor files.
// ----------------------------------------------------------------------------
package vsm_pkg;

   // field widths fixed by the interface
   localparam int CFG_W  = 11;
   localparam int ELEM_W = 16;
   localparam int SUM_W  = 27;

   // shared divider operand widths
   localparam int DIV_NW = 32;
   localparam int DIV_DW = 17;

   localparam logic [CFG_W-1:0]  LEN_RESET     = 11'd64;
   localparam logic [15:0]       RATIO_MAX     = 16'hFFFF;
   localparam logic [DIV_NW-1:0] STAB_DIVIDEND = 32'h1000_0000;
   localparam logic [DIV_DW-1:0] ONE_Q12       = 17'd4096;

   typedef struct packed {
      logic                     mode;
      logic signed [ELEM_W-1:0] element_value;
   } req_word_type;

   typedef struct packed {
      logic [15:0] change_mean;
      logic [15:0] mean_magnitude;
      logic [15:0] stability;
      logic [15:0] convergence;
   } rsp_word_type;

endpackage

### rtl/core/vsm_ram.sv
// ----------------------------------------------------------------------------
// vsm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module vsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/vsm_div.sv
// ----------------------------------------------------------------------------
// vsm_div
// Restoring unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module vsm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vsm_pkg::DIV_NW-1:0]  dividend,
   input  logic [vsm_pkg::DIV_DW-1:0]  divisor,
   output logic                        done,
   output logic [vsm_pkg::DIV_NW-1:0]  quotient
);
   import vsm_pkg::*;

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW:0]   trial;

   // one shift and trial subtract per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_DW]) begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/vector_stability_monitor.sv
// ----------------------------------------------------------------------------
// vector_stability_monitor
// Streams state vectors element by element, compares against the previous
// vector held in RAM and reports change, magnitude, stability and convergence.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | req_word (mode, element_value)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_word (four Q fields)
//   csr     | in        | csr_valid / csr_ready  | csr_data (vector_length)
//
// An element is handled as a previous-vector RAM read, then modify and write.
// A vector's last element runs up to four divisions in the shared bit-serial
// divider (change, magnitude, stability, convergence) and, once the history
// window is full, the history average, which is a reciprocal multiply.
// After reset and after a clear word a sweep over max(MAX_VECTOR_LENGTH,
// HISTORY_WINDOW) addresses zeroes both RAMs; req_ready is low meanwhile.
// A result waits in the output register while the next vector streams in.
// ----------------------------------------------------------------------------
module vector_stability_monitor #(
   parameter int MAX_VECTOR_LENGTH = 1024,
   parameter int HISTORY_WINDOW    = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  vsm_pkg::req_word_type       req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output vsm_pkg::rsp_word_type       rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [vsm_pkg::CFG_W-1:0]   csr_data
);
   import vsm_pkg::*;

   localparam int IDX_W   = MAX_VECTOR_LENGTH > 1 ? $clog2(MAX_VECTOR_LENGTH) : 1;
   localparam int SLOT_W  = HISTORY_WINDOW > 1 ? $clog2(HISTORY_WINDOW) : 1;
   localparam int FILL_W  = $clog2(HISTORY_WINDOW + 1);
   localparam int CMP_W   = (IDX_W > CFG_W ? IDX_W : CFG_W) + 1;
   localparam int HS_W    = 16 + SLOT_W + 1;
   localparam int CLR_N   = MAX_VECTOR_LENGTH > HISTORY_WINDOW ?
                            MAX_VECTOR_LENGTH : HISTORY_WINDOW;
   localparam int CLR_W   = CLR_N > 1 ? $clog2(CLR_N) : 1;
   // history average by reciprocal multiply, exact for every window sum
   localparam int     AVG_SH    = HS_W + SLOT_W;
   localparam int     AVG_PW    = HS_W + AVG_SH + 1;
   localparam longint AVG_RECIP = ((longint'(1) << AVG_SH) + longint'(HISTORY_WINDOW)
                                   - longint'(1)) / longint'(HISTORY_WINDOW);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ELEM,
      S_CR_GO, S_CR_WAIT, S_MM_GO, S_MM_WAIT, S_HIST,
      S_ST_GO, S_ST_WAIT, S_AV, S_CV_CHK,
      S_CV_GO, S_CV_WAIT, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    cs_ff, cs_in;
   logic [SUM_W-1:0]    ms_ff, ms_in;
   logic [HS_W-1:0]     hsum_ff, hsum_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [15:0]         conv_ff, conv_in;
   logic [CFG_W-1:0]    len_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic signed [15:0]  elem_ff, elem_in;
   logic [15:0]         cr_ff, cr_in;
   logic [15:0]         mm_ff, mm_in;
   logic [15:0]         st_ff, st_in;
   logic [15:0]         avg_ff, avg_in;
   logic [15:0]         diff_ff, diff_in;

   logic [CFG_W-1:0]    eff_len;
   logic                last_elem;
   logic signed [16:0]  delta;
   logic [16:0]         chg_abs;
   logic [16:0]         mag_abs;
   logic                req_fire;
   logic                clr_prev_hit, clr_hist_hit;

   logic                prev_we, prev_re;
   logic [IDX_W-1:0]    prev_waddr;
   logic [15:0]         prev_wdata, prev_rdata;
   logic                hist_we, hist_re;
   logic [SLOT_W-1:0]   hist_waddr;
   logic [15:0]         hist_wdata, hist_rdata;

   logic                div_start, div_done;
   logic [DIV_NW-1:0]   div_dividend, div_quotient;
   logic [DIV_DW-1:0]   div_divisor;
   logic [16:0]         conv_wide;
   logic [AVG_PW-1:0]   avg_prod;

   // length register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         len_ff <= csr_data;
      end
   end

   // effective length, clamped to 1..MAX
   always_comb begin
      if (len_ff == '0) begin
         eff_len = CFG_W'(1);
      end else if (32'(len_ff) > 32'(MAX_VECTOR_LENGTH)) begin
         eff_len = CFG_W'(MAX_VECTOR_LENGTH);
      end else begin
         eff_len = len_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign last_elem = (CMP_W'(idx_ff) + CMP_W'(1)) >= CMP_W'(eff_len);

   // element arithmetic against previous vector entry
   assign delta   = 17'(elem_ff) - 17'(signed'(prev_rdata));
   assign chg_abs = delta[16] ? 17'(-delta) : 17'(delta);
   assign mag_abs = elem_ff[15] ? 17'(-17'(elem_ff)) : 17'(elem_ff);

   assign clr_prev_hit = 32'(clr_ff) < 32'(MAX_VECTOR_LENGTH);
   assign clr_hist_hit = 32'(clr_ff) < 32'(HISTORY_WINDOW);

   // previous vector store
   always_comb begin
      prev_re    = req_fire;
      prev_we    = 1'b0;
      prev_waddr = idx_ff;
      prev_wdata = elem_ff;
      if (state_ff == S_CLEAR) begin
         prev_we    = clr_prev_hit;
         prev_waddr = clr_ff[IDX_W-1:0];
         prev_wdata = '0;
      end else if (state_ff == S_ELEM) begin
         prev_we = 1'b1;
      end
   end

   vsm_ram #(.WIDTH(16), .DEPTH(MAX_VECTOR_LENGTH)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (prev_re),
      .rd_addr (idx_ff),
      .rd_data (prev_rdata)
   );

   // magnitude history store
   always_comb begin
      hist_re    = (state_ff == S_ELEM) && last_elem;
      hist_we    = 1'b0;
      hist_waddr = slot_ff;
      hist_wdata = mm_ff;
      if (state_ff == S_CLEAR) begin
         hist_we    = clr_hist_hit;
         hist_waddr = clr_ff[SLOT_W-1:0];
         hist_wdata = '0;
      end else if (state_ff == S_HIST) begin
         hist_we = 1'b1;
      end
   end

   vsm_ram #(.WIDTH(16), .DEPTH(HISTORY_WINDOW)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (hist_re),
      .rd_addr (slot_ff),
      .rd_data (hist_rdata)
   );

   // divider operand select
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_NW'(cs_ff);
      div_divisor  = DIV_DW'(eff_len);
      case (state_ff)
         S_CR_GO: begin
            div_start = 1'b1;
         end
         S_MM_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_NW'(ms_ff);
         end
         S_ST_GO: begin
            div_start    = 1'b1;
            div_dividend = STAB_DIVIDEND;
            div_divisor  = ONE_Q12 + DIV_DW'(cr_ff);
         end
         S_CV_GO: begin
            div_start    = 1'b1;
            div_dividend = {diff_ff, 16'h0000};
            div_divisor  = DIV_DW'(avg_ff);
         end
         default: begin
         end
      endcase
   end

   vsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign conv_wide = 17'h10000 - 17'(div_quotient[15:0]);
   assign avg_prod  = AVG_PW'(hsum_ff) * AVG_PW'(AVG_RECIP);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      cs_in        = cs_ff;
      ms_in        = ms_ff;
      hsum_in      = hsum_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      conv_in      = conv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      elem_in      = elem_ff;
      cr_in        = cr_ff;
      mm_in        = mm_ff;
      st_in        = st_ff;
      avg_in       = avg_ff;
      diff_in      = diff_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == 32'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               elem_in = req_word.element_value;
               if (req_word.mode) begin
                  state_in = S_CLEAR;
                  clr_in   = '0;
                  idx_in   = '0;
                  cs_in    = '0;
                  ms_in    = '0;
                  hsum_in  = '0;
                  slot_in  = '0;
                  fill_in  = '0;
                  conv_in  = '0;
               end else begin
                  state_in = S_ELEM;
               end
            end
         end
         S_ELEM: begin
            cs_in = cs_ff + SUM_W'(chg_abs);
            ms_in = ms_ff + SUM_W'(mag_abs);
            if (last_elem) begin
               state_in = S_CR_GO;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_IDLE;
            end
         end
         S_CR_GO: state_in = S_CR_WAIT;
         S_CR_WAIT: begin
            if (div_done) begin
               cr_in    = (div_quotient[DIV_NW-1:16] != '0) ? RATIO_MAX
                                                            : div_quotient[15:0];
               state_in = S_MM_GO;
            end
         end
         S_MM_GO: state_in = S_MM_WAIT;
         S_MM_WAIT: begin
            if (div_done) begin
               mm_in    = div_quotient[15:0];
               state_in = S_HIST;
            end
         end
         // replace oldest magnitude, keep running window sum
         S_HIST: begin
            hsum_in = hsum_ff - HS_W'(hist_rdata) + HS_W'(mm_ff);
            slot_in = (32'(slot_ff) == 32'(HISTORY_WINDOW - 1)) ? '0
                                                                : slot_ff + SLOT_W'(1);
            if (32'(fill_ff) < 32'(HISTORY_WINDOW)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = S_ST_GO;
         end
         S_ST_GO: state_in = S_ST_WAIT;
         S_ST_WAIT: begin
            if (div_done) begin
               st_in    = (div_quotient[DIV_NW-1:16] != '0) ? RATIO_MAX
                                                            : div_quotient[15:0];
               state_in = (32'(fill_ff) == 32'(HISTORY_WINDOW)) ? S_AV : S_OUT;
            end
         end
         // window average, truncated
         S_AV: begin
            avg_in   = avg_prod[AVG_SH +: 16];
            state_in = S_CV_CHK;
         end
         S_CV_CHK: begin
            diff_in = (mm_ff > avg_ff) ? mm_ff - avg_ff : avg_ff - mm_ff;
            if (avg_ff == '0) begin
               state_in = S_OUT;
            end else if (diff_in >= avg_ff) begin
               conv_in  = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_CV_GO;
            end
         end
         S_CV_GO: state_in = S_CV_WAIT;
         S_CV_WAIT: begin
            if (div_done) begin
               conv_in  = conv_wide[16] ? RATIO_MAX : conv_wide[15:0];
               state_in = S_OUT;
            end
         end
         // hand word to output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.change_mean    = cr_ff;
               rsp_word_in.mean_magnitude = mm_ff;
               rsp_word_in.stability      = st_ff;
               rsp_word_in.convergence    = conv_ff;
               idx_in   = '0;
               cs_in    = '0;
               ms_in    = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         cs_ff        <= '0;
         ms_ff        <= '0;
         hsum_ff      <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         conv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         cs_ff        <= cs_in;
         ms_ff        <= ms_in;
         hsum_ff      <= hsum_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      elem_ff     <= elem_in;
      cr_ff       <= cr_in;
      mm_ff       <= mm_in;
      st_ff       <= st_in;
      avg_ff      <= avg_in;
      diff_ff     <= diff_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
